/* rtl/relocation_field_patch_unit_macros.svh */
// Assertion macros for the relocation field patch RTL.
`ifndef RELOCATION_FIELD_PATCH_UNIT_MACROS_SVH
`define RELOCATION_FIELD_PATCH_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define RFP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("relocation field patch: assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define RFP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("relocation field patch: assertion failed");

`endif

/* rtl/rfp_pkg.sv */
// Types, codes and helper functions for the relocation field patch unit.
package rfp_pkg;

    localparam logic [3:0] FMT_REL8  = 4'd0;
    localparam logic [3:0] FMT_REL11 = 4'd1;
    localparam logic [3:0] FMT_REL12 = 4'd2;
    localparam logic [3:0] FMT_REL19 = 4'd3;
    localparam logic [3:0] FMT_REL22 = 4'd4;
    localparam logic [3:0] FMT_REL24 = 4'd5;
    localparam logic [3:0] FMT_REL32 = 4'd6;
    localparam logic [3:0] FMT_ABS8  = 4'd7;
    localparam logic [3:0] FMT_ABS32 = 4'd8;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_RANGE = 2'd1;
    localparam logic [1:0] ERR_UNSUP = 2'd2;
    localparam logic [1:0] ERR_NONE3 = 2'd3;

    localparam logic       CFG_LITTLE_ENDIAN      = 1'b0;
    localparam logic       CFG_OVERWRITE_RELATIVE = 1'b1;

    localparam logic [31:0] SPLIT19_MASK = 32'h2FFF003F;
    localparam logic [31:0] SPLIT22_MASK = 32'h07FF07FF;
    localparam logic [15:0] REL11_MASK   = 16'h07FF;
    localparam logic [15:0] REL12_MASK   = 16'h0FFF;

    localparam logic [4:0] REL8_BITS  = 5'd8;
    localparam logic [4:0] REL11_BITS = 5'd11;
    localparam logic [4:0] REL12_BITS = 5'd12;
    localparam logic [4:0] REL19_BITS = 5'd19;
    localparam logic [4:0] REL22_BITS = 5'd22;
    localparam logic [4:0] REL24_BITS = 5'd24;

    typedef struct packed {
        logic [3:0]  field_format;
        logic [31:0] site_bytes;
        logic [31:0] site_address;
        logic [31:0] target_address;
        logic [4:0]  shift_right;
        logic        add_existing;
        logic [31:0] fix_offset;
        logic        zero_data;
    } t_item;

    typedef struct packed {
        logic [3:0]  fmt;
        logic [31:0] bytes;
        logic [31:0] tgt;
        logic [4:0]  sh;
        logic        zero;
        logic        abs8_ok;
        logic [31:0] delta;
        logic [31:0] addend;
    } t_s1;

    typedef struct packed {
        logic [3:0]  fmt;
        logic [31:0] bytes;
        logic        abs8_ok;
        logic [31:0] val;
    } t_s2;

    function automatic logic [31:0] f_swap32(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    function automatic logic [31:0] f_rd32(input logic le, input logic [31:0] w);
        return le ? w : f_swap32(w);
    endfunction

    function automatic logic [15:0] f_rd16(input logic le, input logic [31:0] w);
        return le ? w[15:0] : {w[7:0], w[15:8]};
    endfunction

    function automatic logic [31:0] f_sext8(input logic [7:0] b);
        return {{24{b[7]}}, b};
    endfunction

    // True when the magnitude of the signed value is below 2**n.
    function automatic logic f_fits(input logic [31:0] v, input logic [4:0] n);
        logic [31:0] lo_mask;
        logic [31:0] hi;
        lo_mask = (32'h1 << n) - 32'h1;
        hi      = v & ~lo_mask;
        return (hi == 32'h0) || ((hi == ~lo_mask) && ((v & lo_mask) != 32'h0));
    endfunction

endpackage

/* rtl/relocation_field_patch_unit.sv */
// Relocation field patch unit: top level with the pipeline and configuration registers.
// One relocation transaction is taken on every clock edge with start high; busy stays low.
// Each result appears on o_valid exactly four cycles after its start edge, in order,
// and is held for one cycle only: the receiver must take it then. The latency is set by
// the four register stages: input capture, distance and addend, shift and add, and the
// range check with byte packing. Configuration writes take effect at the next edge.
module relocation_field_patch_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic        i_cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  i_field_format,
    input  logic [31:0] i_site_bytes,
    input  logic [31:0] i_site_address,
    input  logic [31:0] i_target_address,
    input  logic [4:0]  i_shift_right,
    input  logic        i_add_existing,
    input  logic signed [31:0] i_fix_offset,
    input  logic        i_zero_data,
    output logic        o_valid,
    output logic [31:0] o_patched_bytes,
    output logic [1:0]  o_error_code
);
    import rfp_pkg::*;

    `include "relocation_field_patch_unit_macros.svh"

    logic        r_little_endian;
    logic        r_overwrite_relative;
    t_item       r_in;
    logic        r_in_vld;
    t_s1         r_s1;
    logic        r_s1_vld;
    t_s2         r_s2;
    logic        r_s2_vld;
    logic [31:0] r_res_bytes;
    logic [1:0]  r_res_err;
    logic        r_res_vld;

    t_s1         n_s1;
    t_s2         n_s2;
    logic [31:0] n_res_bytes;
    logic [1:0]  n_res_err;
    logic [31:0] shifted;
    logic [31:0] base;
    logic [31:0] sum;
    logic        accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_little_endian      <= 1'b1;
            r_overwrite_relative <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_LITTLE_ENDIAN) begin
                r_little_endian <= i_cfg_wdata;
            end
            if (i_cfg_index == CFG_OVERWRITE_RELATIVE) begin
                r_overwrite_relative <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_in_vld  <= accept;
            r_s1_vld  <= r_in_vld;
            r_s2_vld  <= r_s1_vld;
            r_res_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in.field_format   <= i_field_format;
        r_in.site_bytes     <= i_site_bytes;
        r_in.site_address   <= i_site_address;
        r_in.target_address <= i_target_address;
        r_in.shift_right    <= i_shift_right;
        r_in.add_existing   <= i_add_existing;
        r_in.fix_offset     <= i_fix_offset;
        r_in.zero_data      <= i_zero_data;
        r_s1                <= n_s1;
        r_s2                <= n_s2;
        r_res_bytes         <= n_res_bytes;
        r_res_err           <= n_res_err;
    end

    rfp_front u_front (
        .i_item               (r_in),
        .i_little_endian      (r_little_endian),
        .i_overwrite_relative (r_overwrite_relative),
        .o_s1                 (n_s1)
    );

    assign shifted = $signed(r_s1.delta) >>> r_s1.sh;
    assign base    = (r_s1.fmt == FMT_ABS8 || r_s1.fmt == FMT_ABS32) ? r_s1.tgt : shifted;
    assign sum     = base + r_s1.addend;

    always_comb begin
        n_s2.fmt     = r_s1.fmt;
        n_s2.bytes   = r_s1.bytes;
        n_s2.abs8_ok = r_s1.abs8_ok;
        if (r_s1.zero && r_s1.fmt == FMT_REL8) begin
            n_s2.val = f_sext8(r_s1.tgt[7:0]);
        end else if (r_s1.zero && r_s1.fmt <= FMT_REL32) begin
            n_s2.val = r_s1.tgt;
        end else begin
            n_s2.val = sum;
        end
    end

    rfp_pack u_pack (
        .i_s2            (r_s2),
        .i_little_endian (r_little_endian),
        .o_bytes         (n_res_bytes),
        .o_err           (n_res_err)
    );

    assign o_valid         = r_res_vld;
    assign o_patched_bytes = r_res_bytes;
    assign o_error_code    = r_res_err;

    `RFP_ASSERT_IMP(a_latency, accept, ##4 o_valid)
    `RFP_ASSERT_IMP(a_err_code_legal, o_valid, o_error_code != ERR_NONE3)
    `RFP_ASSERT_NEXT(a_unsup_flagged, r_s2_vld && r_s2.fmt > FMT_ABS32, o_error_code == ERR_UNSUP)
    `RFP_ASSERT_NEXT(a_err_passthru, r_s2_vld && n_res_err != ERR_OK,
                     o_patched_bytes == $past(r_s2.bytes))

endmodule

/* rtl/rfp_front.sv */
// Second stage: field extraction, distance and addend for one relocation.
module rfp_front (
    input  rfp_pkg::t_item i_item,
    input  logic           i_little_endian,
    input  logic           i_overwrite_relative,
    output rfp_pkg::t_s1   o_s1
);
    import rfp_pkg::*;

    logic [31:0] old32;
    logic [15:0] old16;
    logic [18:0] ex19;
    logic [21:0] ex22;
    logic [31:0] ext;
    logic        use_ext;
    logic [31:0] pre;
    logic [31:0] fix_add;

    assign old32 = f_rd32(i_little_endian, i_item.site_bytes);
    assign old16 = f_rd16(i_little_endian, i_item.site_bytes);
    assign ex19  = {old32[29], old32[27], old32[5:0], old32[26:16]};
    assign ex22  = {old32[10:0], old32[26:16]};

    always_comb begin
        ext     = 32'h0;
        use_ext = 1'b0;
        unique case (i_item.field_format)
            FMT_REL11: begin
                ext     = {{21{old16[10]}}, old16[10:0]};
                use_ext = i_item.add_existing;
            end
            FMT_REL12: begin
                ext     = {{20{old16[11]}}, old16[11:0]};
                use_ext = i_item.add_existing;
            end
            FMT_REL19: begin
                ext     = {{13{ex19[18]}}, ex19};
                use_ext = i_item.add_existing;
            end
            FMT_REL22: begin
                ext     = {{10{ex22[21]}}, ex22};
                use_ext = i_item.add_existing;
            end
            FMT_REL24: begin
                ext     = {{8{old32[23]}}, old32[23:0]};
                use_ext = i_item.add_existing;
            end
            FMT_REL32: begin
                ext     = old32;
                use_ext = i_item.add_existing;
            end
            FMT_ABS8: begin
                ext     = {24'h0, i_item.site_bytes[7:0]};
                use_ext = i_overwrite_relative;
            end
            FMT_ABS32: begin
                ext     = old32;
                use_ext = i_overwrite_relative && !i_item.zero_data;
            end
            default: begin
                ext     = 32'h0;
                use_ext = 1'b0;
            end
        endcase
    end

    assign pre     = (i_item.field_format == FMT_REL8 && i_item.add_existing)
                     ? f_sext8(i_item.site_bytes[7:0]) : 32'h0;
    assign fix_add = (i_item.field_format == FMT_REL32) ? i_item.fix_offset : 32'h0;

    always_comb begin
        o_s1.fmt     = i_item.field_format;
        o_s1.bytes   = i_item.site_bytes;
        o_s1.tgt     = i_item.target_address;
        o_s1.sh      = i_item.shift_right;
        o_s1.zero    = i_item.zero_data;
        o_s1.abs8_ok = (i_item.target_address[31:7] == 25'h0);
        o_s1.delta   = i_item.target_address - i_item.site_address + pre;
        o_s1.addend  = (use_ext ? ext : 32'h0) + fix_add;
    end

endmodule

/* rtl/rfp_pack.sv */
// Last stage: range check and packing of the value into the site bytes.
module rfp_pack (
    input  rfp_pkg::t_s2 i_s2,
    input  logic         i_little_endian,
    output logic [31:0]  o_bytes,
    output logic [1:0]   o_err
);
    import rfp_pkg::*;

    logic [31:0] old32;
    logic [15:0] old16;
    logic [15:0] new16;
    logic [31:0] new32;
    logic [31:0] res;
    logic        ok;
    logic        supported;

    assign old32 = f_rd32(i_little_endian, i_s2.bytes);
    assign old16 = f_rd16(i_little_endian, i_s2.bytes);

    always_comb begin
        ok        = 1'b1;
        supported = 1'b1;
        new16     = old16;
        new32     = old32;
        res       = i_s2.bytes;
        unique case (i_s2.fmt)
            FMT_REL8: begin
                ok  = f_fits(i_s2.val, REL8_BITS);
                res = {i_s2.bytes[31:8], i_s2.val[7:0]};
            end
            FMT_REL11: begin
                ok    = f_fits(i_s2.val, REL11_BITS);
                new16 = (old16 & ~REL11_MASK) | (i_s2.val[15:0] & REL11_MASK);
                res   = {i_s2.bytes[31:16], f_rd16(i_little_endian, {16'h0, new16})};
            end
            FMT_REL12: begin
                ok    = f_fits(i_s2.val, REL12_BITS);
                new16 = (old16 & ~REL12_MASK) | (i_s2.val[15:0] & REL12_MASK);
                res   = {i_s2.bytes[31:16], f_rd16(i_little_endian, {16'h0, new16})};
            end
            FMT_REL19: begin
                ok    = f_fits(i_s2.val, REL19_BITS);
                new32 = (old32 & ~SPLIT19_MASK)
                        | {2'b0, i_s2.val[18], 1'b0, i_s2.val[17],
                           i_s2.val[10:0], 10'h0, i_s2.val[16:11]};
                res   = f_rd32(i_little_endian, new32);
            end
            FMT_REL22: begin
                ok    = f_fits(i_s2.val, REL22_BITS);
                new32 = (old32 & ~SPLIT22_MASK)
                        | {5'h0, i_s2.val[10:0], 5'h0, i_s2.val[21:11]};
                res   = f_rd32(i_little_endian, new32);
            end
            FMT_REL24: begin
                ok  = f_fits(i_s2.val, REL24_BITS);
                res = f_rd32(i_little_endian, {old32[31:24], i_s2.val[23:0]});
            end
            FMT_REL32: begin
                res = f_rd32(i_little_endian, i_s2.val);
            end
            FMT_ABS8: begin
                ok  = i_s2.abs8_ok;
                res = {i_s2.bytes[31:8], i_s2.val[7:0]};
            end
            FMT_ABS32: begin
                res = f_rd32(i_little_endian, i_s2.val);
            end
            default: begin
                supported = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (!supported) begin
            o_bytes = i_s2.bytes;
            o_err   = ERR_UNSUP;
        end else if (!ok) begin
            o_bytes = i_s2.bytes;
            o_err   = ERR_RANGE;
        end else begin
            o_bytes = res;
            o_err   = ERR_OK;
        end
    end

endmodule
